>>> rtl/core/assert_macros.svh
// Assertion macros shared by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("property failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/sfphm_pkg.sv
// Shared types, constants and functions of the spectral flux peak-hold meter.
package sfphm_pkg;

  localparam int MAG_W = 16;
  localparam int LVL_W = 8;
  localparam int IDX_W = 6;

  localparam int BINS_DFLT = 64;
  localparam int BASS_BINS_DFLT = 10;
  localparam int OUT_DEPTH_DFLT = 8;

  localparam logic [LVL_W-1:0] FALL_STEP_RST = 8'd10;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [LVL_W-1:0] held;
  } bin_entry_t;

  typedef struct packed {
    logic             valid;
    logic             add;
    logic             last;
    logic [LVL_W-1:0] rise;
  } bass_req_t;

  typedef struct packed {
    logic [LVL_W-1:0] bass;
    logic [LVL_W-1:0] smooth;
  } bass_stat_t;

  typedef struct packed {
    logic [LVL_W-1:0] smooth;
    logic [LVL_W-1:0] bass;
    logic             frame_end;
    logic [LVL_W-1:0] level;
    logic [IDX_W-1:0] bin_index;
  } out_item_t;

  function automatic logic [LVL_W-1:0] hold_update(logic [LVL_W-1:0] held,
                                                   logic [LVL_W-1:0] target,
                                                   logic [LVL_W-1:0] step);
    logic [LVL_W-1:0] gap;
    gap = held - target;
    if (target >= held) begin
      return target;
    end
    return held - ((gap < step) ? gap : step);
  endfunction

endpackage

>>> rtl/core/spectral_flux_peak_hold_meter_unit.sv
// Top level of the spectral flux peak-hold meter.
//
// Input stream: one signed Q8.8 bin magnitude per request on s_axis_tdata_i,
// bins 0..BINS-1 of each frame in order. Output stream: one result per input,
// carrying bin index, held level and, on the frame's last bin (m_axis_tlast_o
// high), the bass and smoothed bass levels. fall_step is written through
// cfg_we_i / cfg_wdata_i by the user, only while the block idles; not enforced.
//
// Throughput: one bin per cycle while s_axis_tready_o is high. Each bin does
// one read and one write of the per-bin state memory; reads are issued on
// accept and the write back happens in the next cycle, always to a
// different bin. Each bin then passes rise and hold update, bass multiply
// and bass smoothing stages into the output queue.
//
// Reset: fall_step returns to 10, bass state clears, and a clearing pass
// zeroes all BINS state memory entries; s_axis_tready_o stays low meanwhile.
// Stall: results collect in an OUT_DEPTH entry queue; input is taken while
// the queue plus the three pipeline stages have room, so a stalled receiver
// stops the input once the queue and the stages together hold OUT_DEPTH items.
module spectral_flux_peak_hold_meter_unit import sfphm_pkg::*; #(
  parameter int BINS      = BINS_DFLT,
  parameter int BASS_BINS = BASS_BINS_DFLT,
  parameter int OUT_DEPTH = OUT_DEPTH_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] magnitude
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [5:0] bin_index, [13:6] level,
                                        // [21:14] bass_level,
                                        // [29:22] smooth_bass_level, [31:30] zero
  output logic        m_axis_tlast_o    // frame_end
);

  `include "assert_macros.svh"

  localparam int BinW = $clog2(BINS);
  localparam int CntW = $clog2(OUT_DEPTH + 1);
  localparam int OccW = CntW + 1;

  logic [LVL_W-1:0] fall_step_q;
  logic [BinW-1:0]  bin_cnt_q, bin_cnt_d;
  logic             accept;
  logic             mem_busy;
  bin_entry_t       rd_entry;
  bin_entry_t       wr_entry;

  logic             s1_valid_q;
  logic [MAG_W-1:0] s1_mag_q;
  logic [BinW-1:0]  s1_idx_q;
  logic             s1_last_q;

  logic             s2_valid_q, s3_valid_q;
  logic [IDX_W-1:0] s2_idx_q, s3_idx_q;
  logic [LVL_W-1:0] s2_level_q, s3_level_q;
  logic             s2_last_q, s3_last_q;

  logic signed [MAG_W:0] diff;
  logic [MAG_W-1:0]      pos;
  logic [MAG_W+7:0]      scaled;
  logic [LVL_W-1:0]      rise;
  logic [LVL_W-1:0]      held_new;

  bass_req_t        bass_req;
  bass_stat_t       bass_stat;
  out_item_t        push_item;
  out_item_t        head;
  logic [CntW-1:0]  fifo_cnt;
  logic [OccW-1:0]  occupancy;
  logic             pop;

  assign occupancy = OccW'(fifo_cnt) + OccW'(s1_valid_q) + OccW'(s2_valid_q)
                   + OccW'(s3_valid_q);
  assign s_axis_tready_o = !mem_busy && (occupancy < OccW'(OUT_DEPTH));
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign bin_cnt_d = (bin_cnt_q == BinW'(BINS - 1)) ? '0 : bin_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_step_q <= FALL_STEP_RST;
      bin_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fall_step_q <= cfg_wdata_i;
      end
      if (accept) begin
        bin_cnt_q <= bin_cnt_d;
      end
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mag_q  <= s_axis_tdata_i;
      s1_idx_q  <= bin_cnt_q;
      s1_last_q <= (bin_cnt_q == BinW'(BINS - 1));
    end
    s2_idx_q   <= IDX_W'(s1_idx_q);
    s2_level_q <= held_new;
    s2_last_q  <= s1_last_q;
    s3_idx_q   <= s2_idx_q;
    s3_level_q <= s2_level_q;
    s3_last_q  <= s2_last_q;
  end

  sfphm_bin_mem #(
    .BINS (BINS)
  ) u_bin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (bin_cnt_q),
    .rd_data_o (rd_entry),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (wr_entry),
    .busy_o    (mem_busy)
  );

  always_comb begin
    diff   = $signed({s1_mag_q[MAG_W-1], s1_mag_q})
           - $signed({rd_entry.mag[MAG_W-1], rd_entry.mag});
    pos    = diff[MAG_W-1:0];
    scaled = {pos, 8'b0} - {8'b0, pos};
    if (diff[MAG_W] || (diff == '0)) begin
      rise = '0;
    end else if (|scaled[MAG_W+7:16]) begin
      rise = '1;
    end else begin
      rise = scaled[15:8];
    end
    held_new     = hold_update(rd_entry.held, rise, fall_step_q);
    wr_entry.mag  = s1_mag_q;
    wr_entry.held = held_new;
  end

  always_comb begin
    bass_req.valid = s1_valid_q;
    bass_req.add   = (32'(s1_idx_q) < 32'(BASS_BINS));
    bass_req.last  = s1_last_q;
    bass_req.rise  = rise;
  end

  sfphm_bass #(
    .BASS_BINS (BASS_BINS)
  ) u_bass (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fall_step_i (fall_step_q),
    .req_i       (bass_req),
    .stat_o      (bass_stat)
  );

  always_comb begin
    push_item.bin_index = s3_idx_q;
    push_item.level     = s3_level_q;
    push_item.frame_end = s3_last_q;
    push_item.bass      = bass_stat.bass;
    push_item.smooth    = bass_stat.smooth;
  end

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  sfphm_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tvalid_o = (fifo_cnt != '0);
  assign m_axis_tdata_o  = {2'b00, head.smooth, head.bass, head.level, head.bin_index};
  assign m_axis_tlast_o  = head.frame_end;

  `ASSERT_PROP(a_occupancy_bound, clk_i, rst_ni, occupancy <= OccW'(OUT_DEPTH))
  `ASSERT_PROP(a_last_bin_index, clk_i, rst_ni,
               (m_axis_tvalid_o && m_axis_tlast_o) |->
               (m_axis_tdata_o[5:0] == IDX_W'(BINS - 1)))

endmodule

>>> rtl/core/sfphm_bin_mem.sv
// Per-bin state memory: previous magnitude and held level, with clearing pass.
module sfphm_bin_mem import sfphm_pkg::*; #(
  parameter int BINS = BINS_DFLT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [$clog2(BINS)-1:0] rd_addr_i,
  output bin_entry_t              rd_data_o,
  input  logic                    wr_en_i,
  input  logic [$clog2(BINS)-1:0] wr_addr_i,
  input  bin_entry_t              wr_data_i,
  output logic                    busy_o
);

  `include "assert_macros.svh"

  localparam int AddrW = $clog2(BINS);

  bin_entry_t       mem_q [BINS];
  bin_entry_t       rd_data_q;
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(BINS - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

  `ASSERT_NEVER(a_rd_wr_same_entry, clk_i, rst_ni,
                rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i))

endmodule

>>> rtl/core/sfphm_bass.sv
// Bass rise accumulator, reciprocal divide and smoothed bass tracker.
module sfphm_bass import sfphm_pkg::*; #(
  parameter int BASS_BINS = BASS_BINS_DFLT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] fall_step_i,
  input  bass_req_t        req_i,
  output bass_stat_t       stat_o
);

  localparam int SumW  = $clog2(BASS_BINS * 255 + 1);
  localparam int Shift = SumW + $clog2(BASS_BINS);
  localparam int RecW  = Shift + 1;
  localparam logic [RecW-1:0] Recip = RecW'((2 ** Shift + BASS_BINS - 1) / BASS_BINS);
  localparam int ProdW = SumW + RecW;

  logic [SumW-1:0]  sum_q, sum_d;
  logic [SumW-1:0]  total;
  logic [SumW-1:0]  s2_total_q;
  logic             s2_last_q;
  logic [ProdW-1:0] product;
  logic [LVL_W-1:0] s3_bass_q;
  logic             s3_last_q;
  logic [LVL_W-1:0] smooth_q;
  logic [LVL_W-1:0] smooth_next;

  always_comb begin
    total = sum_q + (req_i.add ? SumW'(req_i.rise) : '0);
    sum_d = sum_q;
    if (req_i.valid) begin
      sum_d = req_i.last ? '0 : total;
    end
  end

  assign product     = ProdW'(s2_total_q) * ProdW'(Recip);
  assign smooth_next = hold_update(smooth_q, s3_bass_q, fall_step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      s2_last_q <= 1'b0;
      s3_last_q <= 1'b0;
      smooth_q  <= '0;
    end else begin
      sum_q     <= sum_d;
      s2_last_q <= req_i.valid && req_i.last;
      s3_last_q <= s2_last_q;
      if (s3_last_q) begin
        smooth_q <= smooth_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_total_q <= total;
    s3_bass_q  <= product[Shift +: LVL_W];
  end

  assign stat_o.bass   = s3_last_q ? s3_bass_q : '0;
  assign stat_o.smooth = s3_last_q ? smooth_next : '0;

endmodule

>>> rtl/core/sfphm_out_fifo.sv
// Result queue between the compute pipeline and the output stream.
module sfphm_out_fifo import sfphm_pkg::*; #(
  parameter int DEPTH = OUT_DEPTH_DFLT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  out_item_t                  push_data_i,
  input  logic                       pop_i,
  output out_item_t                  head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  `include "assert_macros.svh"

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  out_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni,
                push_i && !pop_i && (cnt_q == CntW'(DEPTH)))

endmodule

>>> tb/sv/testbench.sv
// Spectral flux peak-hold meter testbench: directed and random bins checked against a predictor.
module testbench;
  import sfphm_pkg::*;

  localparam int NBINS = BINS_DFLT;
  localparam int NBASS = BASS_BINS_DFLT;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int NPHASES = 6;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    STYLE_DRIFT,
    STYLE_BURST,
    STYLE_DECAY,
    STYLE_NOISE
  } frame_style_t;

  typedef struct {
    logic [IDX_W-1:0] bin_index;
    logic [LVL_W-1:0] level;
    logic             frame_end;
    logic [LVL_W-1:0] bass;
    logic [LVL_W-1:0] smooth;
  } meter_result_t;

  class flux_meter_scoreboard;
    logic [MAG_W-1:0] last_frame_mag[NBINS];
    logic [LVL_W-1:0] held_lvl[NBINS];
    int               bin_pos;
    int               bass_acc;
    logic [LVL_W-1:0] bass_smooth;
    logic [LVL_W-1:0] fall_step;
    meter_result_t    pending_levels[$];
    int               mismatches;

    function new();
      foreach (last_frame_mag[i]) begin
        last_frame_mag[i] = '0;
        held_lvl[i] = '0;
      end
      bin_pos = 0;
      bass_acc = 0;
      bass_smooth = '0;
      fall_step = FALL_STEP_RST;
      mismatches = 0;
    endfunction

    function logic [LVL_W-1:0] limited_fall(logic [LVL_W-1:0] held, logic [LVL_W-1:0] target);
      logic [LVL_W-1:0] gap;
      if (target >= held) begin
        return target;
      end
      gap = held - target;
      return held - ((gap < fall_step) ? gap : fall_step);
    endfunction

    function void note_request(logic [MAG_W-1:0] mag);
      int               diff;
      int               scaled;
      logic [LVL_W-1:0] rise;
      meter_result_t    r;
      diff = int'($signed(mag)) - int'($signed(last_frame_mag[bin_pos]));
      rise = '0;
      if (diff > 0) begin
        scaled = (diff * 255) >> 8;
        rise = (scaled > 255) ? 8'd255 : LVL_W'(scaled);
      end
      held_lvl[bin_pos] = limited_fall(held_lvl[bin_pos], rise);
      last_frame_mag[bin_pos] = mag;
      if (bin_pos < NBASS) begin
        bass_acc += rise;
      end
      r.bin_index = IDX_W'(bin_pos);
      r.level = held_lvl[bin_pos];
      r.frame_end = (bin_pos == NBINS - 1);
      r.bass = '0;
      r.smooth = '0;
      if (r.frame_end) begin
        r.bass = LVL_W'(bass_acc / NBASS);
        bass_smooth = limited_fall(bass_smooth, r.bass);
        r.smooth = bass_smooth;
        bass_acc = 0;
        bin_pos = 0;
      end else begin
        bin_pos++;
      end
      pending_levels = {pending_levels, r};
    endfunction

    function void check_result(logic [31:0] data, logic last);
      meter_result_t e;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no pending request: tdata=%h tlast=%b", data, last);
        end
        return;
      end
      e = pending_levels.pop_front();
      if (data[5:0] !== e.bin_index || data[13:6] !== e.level || last !== e.frame_end ||
          data[21:14] !== e.bass || data[29:22] !== e.smooth || data[31:30] !== 2'b00) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: bin %0d level %0d end %b bass %0d smooth %0d pad 0",
                   e.bin_index, e.level, e.frame_end, e.bass, e.smooth);
          $display("         got: bin %0d level %0d end %b bass %0d smooth %0d pad %0d",
                   data[5:0], data[13:6], last, data[21:14], data[29:22], data[31:30]);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  flux_meter_scoreboard sb;
  int unsigned          cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  logic [MAG_W-1:0]     sent_mag[NBINS];
  int                   gen_bin = 0;

  spectral_flux_peak_hold_meter_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[spectral_flux_peak_hold_meter_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_request(s_axis_tdata_i);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  function automatic logic [MAG_W-1:0] pick_magnitude(frame_style_t style);
    int v;
    int base;
    base = int'($signed(sent_mag[gen_bin]));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    case (style)
      STYLE_BURST: v = (base > 30000) ? -32768 : base + int'($urandom_range(2047, 256));
      STYLE_DECAY: v = base - int'($urandom_range(64));
      STYLE_NOISE: return 16'($urandom);
      default: v = base + int'($urandom_range(1024)) - 512;
    endcase
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return MAG_W'(v);
  endfunction

  task automatic send_bin(input logic [MAG_W-1:0] mag);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= mag;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_mag[gen_bin] = mag;
    gen_bin = (gen_bin + 1) % NBINS;
  endtask

  task automatic drain_results();
    do @(posedge clk_i); while (sb.pending_levels.size() != 0);
  endtask

  task automatic write_fall_step(input logic [7:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.fall_step = value;
  endtask

  initial begin
    logic [MAG_W-1:0] directed_mags[16];
    logic [LVL_W-1:0] fall_steps[NPHASES];
    frame_style_t     style;
    int               p;
    int               n;
    sb = new();
    foreach (sent_mag[i]) begin
      sent_mag[i] = '0;
    end
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    directed_mags = '{16'h7FFF, 16'h8000, 16'h0001, 16'h0002, 16'h0100, 16'h0101,
                      16'hFFFF, 16'h0000, 16'h00FF, 16'h7FFF, 16'h8000, 16'h8001,
                      16'h4000, 16'hC000, 16'h0080, 16'h5555};
    fall_steps = '{8'd0, 8'd255, 8'd1, 8'd32, 8'($urandom_range(2, 254)), 8'd10};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_mags[i]) begin
      send_bin(directed_mags[i]);
    end

    style = STYLE_DRIFT;
    for (p = 0; p < NPHASES; p++) begin
      s_axis_tvalid_i <= 1'b0;
      drain_results();
      write_fall_step(fall_steps[p]);
      if (p < 2) begin
        send_idle_pct = 12;
        recv_stall_pct = 67;
      end else if (p < 4) begin
        send_idle_pct = 67;
        recv_stall_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (gen_bin == 0) begin
          style = frame_style_t'($urandom_range(3));
        end
        send_bin(pick_magnitude(style));
      end
    end

    s_axis_tvalid_i <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_levels.size() == 0) begin
      $display("[spectral_flux_peak_hold_meter_unit] OK");
    end else begin
      $display("[spectral_flux_peak_hold_meter_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sfphm_pkg.sv
rtl/core/sfphm_bin_mem.sv
rtl/core/sfphm_bass.sv
rtl/core/sfphm_out_fifo.sv
rtl/core/spectral_flux_peak_hold_meter_unit.sv
tb/sv/testbench.sv
